FILE: design/ims_pkg.sv
// ims_pkg: types, status codes and control masks shared by the
// status-driven I2C master sequencer. No dependencies.
package ims_pkg;

  // request kinds carried in req_type
  typedef enum logic [1:0] {
    REQ_LOAD   = 2'd0,
    REQ_START  = 2'd1,
    REQ_STATUS = 2'd2,
    REQ_DRAIN  = 2'd3
  } ims_req_t;

  // engine mode, also reported as engine_state
  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_BUSY   = 2'd1,
    MODE_FAILED = 2'd2,
    MODE_DATAV  = 2'd3
  } ims_mode_t;

  // transfer mode codes; the spare code behaves as a read
  localparam logic [1:0] XFER_WRITE      = 2'd0;
  localparam logic [1:0] XFER_READ       = 2'd1;
  localparam logic [1:0] XFER_WRITE_READ = 2'd2;
  localparam logic [1:0] XFER_SPARE      = 2'd3;

  // controller status codes
  localparam logic [7:0] ST_START       = 8'h08;
  localparam logic [7:0] ST_RESTART     = 8'h10;
  localparam logic [7:0] ST_SLA_W_ACK   = 8'h18;
  localparam logic [7:0] ST_SLA_W_NACK  = 8'h20;
  localparam logic [7:0] ST_DATA_W_ACK  = 8'h28;
  localparam logic [7:0] ST_DATA_W_NACK = 8'h30;
  localparam logic [7:0] ST_ARB_LOST    = 8'h38;
  localparam logic [7:0] ST_SLA_R_ACK   = 8'h40;
  localparam logic [7:0] ST_SLA_R_NACK  = 8'h48;
  localparam logic [7:0] ST_DATA_R_ACK  = 8'h50;
  localparam logic [7:0] ST_DATA_R_NACK = 8'h58;

  // control register bits
  localparam logic [6:0] CTL_AA  = 7'h04;
  localparam logic [6:0] CTL_SI  = 7'h08;
  localparam logic [6:0] CTL_STO = 7'h10;
  localparam logic [6:0] CTL_STA = 7'h20;
  localparam logic [6:0] CTL_EN  = 7'h40;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] target_addr;
    logic [1:0] xfer_mode;
    logic [4:0] send_count;
    logic [4:0] recv_count;
    logic [3:0] buf_index;
    logic [7:0] byte_in;
    logic [7:0] status_code;
    logic       drain_last;
  } ims_in_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] byte_out;
    logic       byte_out_valid;
    logic [6:0] ctrl_set_mask;
    logic [6:0] ctrl_clear_mask;
    logic [1:0] engine_state;
  } ims_out_t;

  typedef struct packed {
    logic [7:0] byte_counter;
    logic [7:0] addr_byte;
    logic [4:0] send_total;
    logic [4:0] recv_total;
    logic       then_read;
    ims_mode_t  mode;
  } ims_state_t;

  // store write requests raised by one transaction
  typedef struct packed {
    logic       tx_we;
    logic [7:0] tx_idx;
    logic [7:0] tx_data;
    logic       rx_we;
    logic       rx_clr;
    logic [7:0] rx_idx;
    logic [7:0] rx_data;
  } ims_wr_t;

endpackage

FILE: design/i2c_master_status_sequencer.sv
// i2c_master_status_sequencer_unit: top level of the status-driven I2C
// master sequencer. Depends on ims_pkg, ims_ram and ims_step.
//
// While results are taken, one transaction enters and one result leaves per clock for
// every request: loading a transmit byte, asking for a transfer, reporting
// a controller status code, or draining a received byte. A result passes
// through the input register, then the result register, and is held on
// the result port until taken; the sustained rate is one per cycle while
// results are taken, as each transaction needs a single pass through
// the decision logic and one read of each byte store, issued when
// the request is taken. Requests keep flowing while a result waits to be
// taken; back-pressure on the result side reaches the request side only
// once the input register is also full. The receive store reads as zero
// after reset through per-entry valid bits, so no clearing pass is needed.
// Reading a transmit slot that was never loaded returns an undefined byte.
module i2c_master_status_sequencer_unit import ims_pkg::*; #(
  parameter int TX_DEPTH = 16,
  parameter int RX_DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  ims_in_t  req_data,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output ims_out_t rsp_data
);

  localparam int TxAw = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int RxAw = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;

  // input register
  ims_in_t    in_q;
  logic       in_vld;

  // engine state
  ims_state_t st;
  ims_state_t st_next;
  ims_state_t st_eff;

  ims_out_t   res;
  ims_wr_t    wr;

  logic       fire;
  logic       accept;

  logic [7:0]      tx_rd_cnt;
  logic [7:0]      tx_rdata;
  logic [7:0]      rx_rdata;
  logic [7:0]      rx_word;
  logic [7:0]      rx_rd_wide;
  logic [7:0]      rx_q_wide;
  logic [RX_DEPTH-1:0] rx_vld;

  // advance the work stage when its result has somewhere to go
  assign fire      = in_vld && (!rsp_valid || rsp_ready);
  assign req_ready = !in_vld || fire;
  assign accept    = req_valid && req_ready;

  // state as it stands once the transaction in work has retired
  assign st_eff = fire ? st_next : st;

  // a data-acked status fetches the slot after the one just sent
  assign tx_rd_cnt = st_eff.byte_counter +
                     (((req_data.req_type == REQ_STATUS) &&
                       (req_data.status_code == ST_DATA_W_ACK)) ? 8'd1 : 8'd0);

  assign rx_rd_wide = {4'b0000, req_data.buf_index};
  assign rx_q_wide  = {4'b0000, in_q.buf_index};

  // an entry never written or already drained reads as zero
  assign rx_word = rx_vld[rx_q_wide[RxAw-1:0]] ? rx_rdata : 8'h00;

  ims_ram #(
    .WIDTH (8),
    .DEPTH (TX_DEPTH)
  ) u_tx_ram (
    .clk   (clk),
    .we    (fire && wr.tx_we),
    .waddr (wr.tx_idx[TxAw-1:0]),
    .wdata (wr.tx_data),
    .re    (accept),
    .raddr (tx_rd_cnt[TxAw-1:0]),
    .rdata (tx_rdata)
  );

  ims_ram #(
    .WIDTH (8),
    .DEPTH (RX_DEPTH)
  ) u_rx_ram (
    .clk   (clk),
    .we    (fire && wr.rx_we),
    .waddr (wr.rx_idx[RxAw-1:0]),
    .wdata (wr.rx_data),
    .re    (accept),
    .raddr (rx_rd_wide[RxAw-1:0]),
    .rdata (rx_rdata)
  );

  ims_step #(
    .TX_DEPTH (TX_DEPTH),
    .RX_DEPTH (RX_DEPTH)
  ) u_step (
    .item    (in_q),
    .st      (st),
    .tx_word (tx_rdata),
    .rx_word (rx_word),
    .st_next (st_next),
    .res     (res),
    .wr      (wr)
  );

  // capture the incoming transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (req_ready) begin
      in_vld <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_q <= req_data;
    end
  end

  // commit engine state and receive valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      st.byte_counter <= '0;
      st.addr_byte    <= '0;
      st.send_total   <= '0;
      st.recv_total   <= '0;
      st.then_read    <= 1'b0;
      st.mode         <= MODE_IDLE;
      rx_vld          <= '0;
    end else if (fire) begin
      st <= st_next;
      if (wr.rx_we) begin
        rx_vld[wr.rx_idx[RxAw-1:0]] <= 1'b1;
      end
      if (wr.rx_clr) begin
        rx_vld[wr.rx_idx[RxAw-1:0]] <= 1'b0;
      end
    end
  end

  // result register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (fire) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp_data <= res;
    end
  end

endmodule

FILE: design/ims_ram.sv
// ims_ram: generic single-write, single-read RAM with registered,
// write-first read data. No dependencies.
module ims_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // forward a same-cycle write so the reader sees the newest value
  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata <= wdata;
      end else begin
        rdata <= mem[raddr];
      end
    end
  end

endmodule

FILE: design/ims_step.sv
// ims_step: next-state and result decision for one transaction.
// Depends on ims_pkg.
module ims_step import ims_pkg::*; #(
  parameter int TX_DEPTH = 16,
  parameter int RX_DEPTH = 16
) (
  input  ims_in_t    item,
  input  ims_state_t st,
  input  logic [7:0] tx_word,
  input  logic [7:0] rx_word,
  output ims_state_t st_next,
  output ims_out_t   res,
  output ims_wr_t    wr
);

  localparam logic [8:0] TxLim = 9'(TX_DEPTH);
  localparam logic [8:0] RxLim = 9'(RX_DEPTH);

  logic [7:0] cnt_inc;
  logic [8:0] cnt_inc2;
  logic [7:0] idx_wide;

  always_comb begin
    cnt_inc  = st.byte_counter + 8'd1;
    cnt_inc2 = {1'b0, cnt_inc} + 9'd1;
    idx_wide = {4'b0000, item.buf_index};

    st_next = st;
    res     = '0;
    wr      = '0;
    wr.tx_idx  = idx_wide;
    wr.tx_data = item.byte_in;
    wr.rx_idx  = st.byte_counter;
    wr.rx_data = item.byte_in;

    case (item.req_type)
      REQ_LOAD: begin
        wr.tx_we = ({1'b0, idx_wide} < TxLim);
      end
      REQ_START: begin
        if (st.mode != MODE_BUSY && st.mode != MODE_DATAV) begin
          st_next.addr_byte  = {item.target_addr, item.xfer_mode[0]};
          st_next.send_total = item.send_count;
          st_next.recv_total = item.recv_count;
          st_next.then_read  = (item.xfer_mode == XFER_WRITE_READ);
          st_next.mode       = MODE_BUSY;
          res.ctrl_clear_mask = CTL_SI;
          res.ctrl_set_mask   = CTL_EN | CTL_STA;
          res.accepted        = 1'b1;
        end
      end
      REQ_STATUS: begin
        res.ctrl_clear_mask = CTL_STA | CTL_SI;
        case (item.status_code)
          ST_START, ST_RESTART: begin
            res.byte_out       = st.addr_byte;
            res.byte_out_valid = 1'b1;
          end
          ST_SLA_W_ACK: begin
            if ({1'b0, st.byte_counter} < TxLim) begin
              res.byte_out       = tx_word;
              res.byte_out_valid = 1'b1;
            end
          end
          ST_SLA_W_NACK: begin
            res.ctrl_set_mask    = CTL_EN | CTL_STO;
            st_next.mode         = MODE_FAILED;
            st_next.byte_counter = '0;
          end
          ST_DATA_W_ACK: begin
            if (cnt_inc >= {3'b000, st.send_total}) begin
              if (st.then_read) begin
                res.ctrl_set_mask    = CTL_STA;
                st_next.addr_byte[0] = 1'b1;
              end else begin
                res.ctrl_set_mask = CTL_STO;
                st_next.mode      = MODE_IDLE;
              end
              st_next.byte_counter = '0;
            end else begin
              st_next.byte_counter = cnt_inc;
              if ({1'b0, cnt_inc} < TxLim) begin
                res.byte_out       = tx_word;
                res.byte_out_valid = 1'b1;
              end
            end
          end
          ST_DATA_W_NACK: begin
            res.ctrl_set_mask    = CTL_EN | CTL_STO;
            st_next.mode         = MODE_IDLE;
            st_next.byte_counter = '0;
          end
          ST_ARB_LOST: begin
            st_next.byte_counter = '0;
          end
          ST_SLA_R_ACK: begin
            res.ctrl_set_mask = CTL_AA;
          end
          ST_SLA_R_NACK: begin
            res.ctrl_set_mask    = CTL_STO;
            st_next.mode         = MODE_FAILED;
            st_next.byte_counter = '0;
          end
          ST_DATA_R_ACK: begin
            wr.rx_we             = ({1'b0, st.byte_counter} < RxLim);
            st_next.byte_counter = cnt_inc;
            // withdraw the ACK ahead of the last expected byte
            if (cnt_inc2 >= {4'b0000, st.recv_total}) begin
              res.ctrl_clear_mask = CTL_STA | CTL_SI | CTL_AA;
            end else begin
              res.ctrl_set_mask = CTL_AA;
            end
          end
          ST_DATA_R_NACK: begin
            wr.rx_we             = ({1'b0, st.byte_counter} < RxLim);
            res.ctrl_set_mask    = CTL_STO;
            st_next.mode         = MODE_DATAV;
            st_next.byte_counter = '0;
          end
          default: begin
          end
        endcase
      end
      REQ_DRAIN: begin
        if (st.mode == MODE_DATAV) begin
          if ({1'b0, idx_wide} < RxLim) begin
            res.byte_out = rx_word;
            wr.rx_clr    = 1'b1;
            wr.rx_idx    = idx_wide;
          end
          res.byte_out_valid = 1'b1;
          res.accepted       = 1'b1;
        end
        if (item.drain_last) begin
          st_next.mode = MODE_IDLE;
        end
      end
      default: begin
      end
    endcase

    res.engine_state = st_next.mode;
  end

endmodule

FILE: design/ims_checker.sv
// ims_checker: port-level assertions for the sequencer top level, and
// the bind that attaches them. Depends on ims_pkg.
module ims_checker import ims_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     req_ready,
  input logic     rsp_valid,
  input logic     rsp_ready,
  input ims_out_t rsp_data
);

  // hold a stalled result unchanged
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
    else $error("stalled result changed or dropped");

  // an empty result register never blocks requests
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !rsp_valid |-> req_ready)
    else $error("request blocked while result side empty");

  // drop every result on reset
  a_reset_clears: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result pending after reset");

  // a byte value only travels with its valid flag
  a_byte_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_data.byte_out != 8'h00) |-> rsp_data.byte_out_valid)
    else $error("byte_out set without byte_out_valid");

endmodule

bind i2c_master_status_sequencer_unit ims_checker u_ims_checker (
  .clk       (clk),
  .rst       (rst),
  .req_ready (req_ready),
  .rsp_valid (rsp_valid),
  .rsp_ready (rsp_ready),
  .rsp_data  (rsp_data)
);
